// ===== rtl/lphm_pkg.sv =====
package lphm_pkg;

   // table geometry
   localparam int CAPACITY   = 1024;
   localparam int IDX_W      = $clog2(CAPACITY);
   localparam int CNT_W      = IDX_W + 1;
   // a put is refused once the entry count reaches three quarters of the table
   localparam int LOAD_LIMIT = (CAPACITY * 3) / 4;

   // hash constants
   localparam logic [63:0] HASH_MULT  = 64'hff51_afd7_ed55_8ccd;
   localparam int          HASH_SHIFT = 33;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_MISS   = 2'd1,
      ST_FULL   = 2'd2,
      ST_BADKEY = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      FN_PUT   = 2'd0,
      FN_GET   = 2'd1,
      FN_CLEAR = 2'd2,
      FN_NOP   = 2'd3
   } func_type;

   // operation as classified by the front end
   typedef enum logic [2:0] {
      OP_PUT    = 3'd0,
      OP_GET    = 3'd1,
      OP_CLEAR  = 3'd2,
      OP_NOP    = 3'd3,
      OP_BADKEY = 3'd4,
      OP_MISS   = 3'd5
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [63:0]      key;
      logic [63:0]      value;
      logic [IDX_W-1:0] home;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

endpackage

// ===== rtl/lphm_queue.sv =====
module lphm_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  lphm_pkg::entry_type push_entry,
   input  logic                pop,
   output lphm_pkg::entry_type head,
   output lphm_pkg::q_status_type status
);
   import lphm_pkg::*;

   entry_type  slots_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_push, do_pop;

   assign do_push = push && (fill_ff != 2'd2);
   assign do_pop  = pop && (fill_ff != 2'd0);

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head         = slots_ff[rd_ptr_ff];
   assign status.empty = (fill_ff == 2'd0);
   assign status.full  = (fill_ff == 2'd2);

endmodule

// ===== rtl/lphm_front.sv =====
module lphm_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic [1:0]            func,
   input  logic [63:0]           key,
   input  logic [63:0]           value,
   input  logic                  back_init,
   input  lphm_pkg::q_status_type q_status,
   output logic                  q_push,
   output lphm_pkg::entry_type   q_entry
);
   import lphm_pkg::*;

   typedef enum logic [3:0] {
      F_IDLE = 4'b0001,
      F_MUL0 = 4'b0010,
      F_MUL1 = 4'b0100,
      F_MUL2 = 4'b1000
   } fstate_type;

   fstate_type  state_ff, state_in;
   op_type      op_ff, op_in;
   logic [63:0] key_ff, value_ff;
   logic [63:0] mix_ff;     // key after the first xor-shift
   logic [63:0] acc_ff, acc_in;
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic [63:0] acc_sum, hash;
   logic        accept;

   assign full   = (state_ff != F_IDLE) || back_init;
   assign accept = push && !full;

   // classify at acceptance
   always_comb begin
      unique case (func_type'(func))
         FN_PUT:   op_in = (key == 64'd0) ? OP_BADKEY : OP_PUT;
         FN_GET:   op_in = (key == 64'd0) ? OP_MISS : OP_GET;
         FN_CLEAR: op_in = OP_CLEAR;
         default:  op_in = OP_NOP;
      endcase
   end

   // one shared 32x32 multiplier, three partial products for the low 64 bits
   always_comb begin
      mul_a = mix_ff[31:0];
      mul_b = HASH_MULT[31:0];
      if (state_ff == F_MUL1) begin
         mul_b = HASH_MULT[63:32];
      end else if (state_ff == F_MUL2) begin
         mul_a = mix_ff[63:32];
      end
   end

   assign mul_p   = {32'd0, mul_a} * {32'd0, mul_b};
   assign acc_sum = acc_ff + {mul_p[31:0], 32'd0};
   assign hash    = acc_sum ^ (acc_sum >> HASH_SHIFT);

   always_comb begin
      state_in = state_ff;
      acc_in   = acc_ff;
      q_push   = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) state_in = F_MUL0;
         end
         F_MUL0: begin
            acc_in   = mul_p;
            state_in = F_MUL1;
         end
         F_MUL1: begin
            acc_in   = acc_sum;
            state_in = F_MUL2;
         end
         F_MUL2: begin
            if (!q_status.full) begin
               q_push   = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (accept) begin
         op_ff    <= op_in;
         key_ff   <= key;
         value_ff <= value;
         mix_ff   <= key ^ (key >> HASH_SHIFT);
      end
   end

   assign q_entry.op    = op_ff;
   assign q_entry.key   = key_ff;
   assign q_entry.value = value_ff;
   assign q_entry.home  = hash[IDX_W-1:0];

endmodule

// ===== rtl/lphm_back.sv =====
module lphm_back (
   input  logic                   clock,
   input  logic                   reset,
   input  lphm_pkg::q_status_type q_status,
   input  lphm_pkg::entry_type    q_head,
   output logic                   q_pop,
   output logic                   init_busy,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [1:0]             rsp_status,
   output logic [63:0]            rsp_found_value
);
   import lphm_pkg::*;

   typedef enum logic [4:0] {
      B_INIT  = 5'b00001,
      B_IDLE  = 5'b00010,
      B_PROBE = 5'b00100,
      B_CLEAR = 5'b01000,
      B_RESP  = 5'b10000
   } bstate_type;

   bstate_type       state_ff, state_in;
   op_type           op_ff, op_in;
   logic [63:0]      key_ff, value_ff;
   logic [IDX_W-1:0] probe_ff, probe_in;
   logic [IDX_W-1:0] sweep_ff, sweep_in;
   logic [CNT_W-1:0] count_ff, count_in;
   status_type       res_status_ff, res_status_in;
   logic [63:0]      res_found_ff, res_found_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_status_ff;
   logic [63:0]      rsp_found_ff;
   logic             rsp_load;

   // table memories
   logic             used_mem [CAPACITY];
   logic [63:0]      key_mem  [CAPACITY];
   logic [63:0]      val_mem  [CAPACITY];
   logic             used_rd_ff;
   logic [63:0]      key_rd_ff, val_rd_ff;
   logic [IDX_W-1:0] rd_addr, used_wa;
   logic             used_we, used_wd, key_we, val_we;
   logic             sweep_last;

   assign sweep_last = (sweep_ff == IDX_W'(CAPACITY - 1));

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      probe_in      = probe_ff;
      sweep_in      = sweep_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      rsp_load      = 1'b0;
      q_pop         = 1'b0;
      rd_addr       = probe_ff;
      used_we       = 1'b0;
      used_wd       = 1'b0;
      used_wa       = probe_ff;
      key_we        = 1'b0;
      val_we        = 1'b0;
      unique case (state_ff) inside
         B_INIT, B_CLEAR: begin
            used_we  = 1'b1;
            used_wa  = sweep_ff;
            sweep_in = sweep_ff + IDX_W'(1);
            count_in = '0;
            if (sweep_last) begin
               state_in = (state_ff == B_INIT) ? B_IDLE : B_RESP;
            end
         end
         B_IDLE: begin
            rd_addr = q_head.home;
            if (!q_status.empty) begin
               q_pop         = 1'b1;
               op_in         = q_head.op;
               probe_in      = q_head.home;
               res_status_in = ST_OK;
               res_found_in  = 64'd0;
               state_in      = B_RESP;
               unique case (q_head.op)
                  OP_PUT: begin
                     if (count_ff >= CNT_W'(LOAD_LIMIT)) begin
                        res_status_in = ST_FULL;
                     end else begin
                        state_in = B_PROBE;
                     end
                  end
                  OP_GET:    state_in = B_PROBE;
                  OP_CLEAR: begin
                     sweep_in = '0;
                     state_in = B_CLEAR;
                  end
                  OP_BADKEY: res_status_in = ST_BADKEY;
                  OP_MISS:   res_status_in = ST_MISS;
                  default:   res_status_in = ST_OK;
               endcase
            end
         end
         B_PROBE: begin
            rd_addr = probe_ff + IDX_W'(1);
            if (!used_rd_ff) begin
               state_in = B_RESP;
               if (op_ff == OP_PUT) begin
                  used_we       = 1'b1;
                  used_wd       = 1'b1;
                  key_we        = 1'b1;
                  val_we        = 1'b1;
                  count_in      = count_ff + CNT_W'(1);
                  res_status_in = ST_OK;
               end else begin
                  res_status_in = ST_MISS;
               end
            end else if (key_rd_ff == key_ff) begin
               state_in      = B_RESP;
               res_status_in = ST_OK;
               if (op_ff == OP_PUT) begin
                  val_we = 1'b1;
               end else begin
                  res_found_in = val_rd_ff;
               end
            end else begin
               probe_in = probe_ff + IDX_W'(1);
            end
         end
         B_RESP: begin
            if (!rsp_valid_ff || rsp_pop) begin
               rsp_load = 1'b1;
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_INIT;
         sweep_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      probe_ff      <= probe_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      if (q_pop) begin
         key_ff   <= q_head.key;
         value_ff <= q_head.value;
      end
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_found_ff  <= res_found_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (used_we) used_mem[used_wa] <= used_wd;
      if (key_we)  key_mem[probe_ff] <= key_ff;
      if (val_we)  val_mem[probe_ff] <= value_ff;
      used_rd_ff <= used_mem[rd_addr];
      key_rd_ff  <= key_mem[rd_addr];
      val_rd_ff  <= val_mem[rd_addr];
   end

   assign init_busy       = (state_ff == B_INIT);
   assign rsp_empty       = !rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_value = rsp_found_ff;

endmodule

// ===== rtl/linear_probe_hash_map.sv =====
// linear-probing key/value map, 1024 slots of 64-bit key and 64-bit value.
// func 0 puts (insert or overwrite), 1 gets, 2 clears the table, 3 does nothing;
// every request gives exactly one response, in order. status is 0 done/found,
// 1 not found, 2 table full (entry count has reached three quarters of capacity),
// 3 zero key on put. found_value is nonzero only for a successful get.
// the front end takes a new request only after it has pushed the last one into
// the queue (the hash runs three partial products through one shared 32x32
// multiplier); a 2-entry queue feeds the probe engine, which pops a request,
// visits slots one at a time (one read port per table memory) and posts the
// response; a request that needs no probe skips the visits. a clear sweeps the used
// bits at one slot per cycle. after reset the same sweep runs with req_full held
// high. one response register sits on the output, so the probe engine can finish
// the next request while a response waits for rsp_pop; after that the queue and
// front end fill up and req_full rises.
module linear_probe_hash_map (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_func,
   input  logic [63:0] req_key,
   input  logic [63:0] req_value,
   // response channel
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_status,
   output logic [63:0] rsp_found_value
);
   import lphm_pkg::*;

   entry_type    q_in_entry, q_head;
   q_status_type q_status;
   logic         q_push, q_pop;
   logic         init_busy;

   // hash and classify, one request at a time
   lphm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .full      (req_full),
      .func      (req_func),
      .key       (req_key),
      .value     (req_value),
      .back_init (init_busy),
      .q_status  (q_status),
      .q_push    (q_push),
      .q_entry   (q_in_entry)
   );

   // decouples hashing from probing
   lphm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in_entry),
      .pop        (q_pop),
      .head       (q_head),
      .status     (q_status)
   );

   // probe engine, table memories and response register
   lphm_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_status        (q_status),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .init_busy       (init_busy),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_status      (rsp_status),
      .rsp_found_value (rsp_found_value)
   );

endmodule
